/* src/msp_pkg.sv */
// ============================================================================
// msp_pkg
// Shared types and constants of the multichannel servo pulse generator.
// ============================================================================
package msp_pkg;

  // Channel count and channel addressing
  localparam int CHANNELS = 8;
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_FW    = 3;
  localparam logic [7:0] CHAN_BITS = 8'((1 << CHANNELS) - 1);

  // Angle range and the "no angle set" code
  localparam logic [7:0] ANGLE_MAX = 8'd180;
  localparam logic [7:0] NO_ANGLE  = 8'hff;

  // Input beat kinds (carried on s_tuser)
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_ANGLE = 2'd1;
  localparam logic [1:0] ACT_WIDTH = 2'd2;
  localparam logic [1:0] ACT_FORCE = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_MIN    = 3'd0;
  localparam logic [2:0] REG_MAX    = 3'd1;
  localparam logic [2:0] REG_PERIOD = 3'd2;
  localparam logic [2:0] REG_ENABLE = 3'd3;
  localparam logic [2:0] REG_INVERT = 3'd4;

  // Register reset values
  localparam logic [15:0] MIN_RESET    = 16'd544;
  localparam logic [15:0] MAX_RESET    = 16'd2400;
  localparam logic [15:0] PERIOD_RESET = 16'd20000;

  // One channel entry of the state memory
  typedef struct packed {
    logic [15:0] latched;
    logic [7:0]  angle;
    logic [15:0] width;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);
  localparam ent_t ENT_RESET = '{latched: 16'd0, angle: NO_ANGLE, width: 16'd0};

  // Sweep kinds over the channel memory
  localparam logic [1:0] MODE_FRAME  = 2'd0;
  localparam logic [1:0] MODE_EXPIRE = 2'd1;
  localparam logic [1:0] MODE_CLAMP  = 2'd2;

  // Serial divider: dividend bits (180 * 65535 fits in 24 bits)
  localparam int DIV_W  = 24;
  localparam int DIV_CW = $clog2(DIV_W);

endpackage

/* src/multichannel_servo_pulse_generator.sv */
// ============================================================================
// multichannel_servo_pulse_generator
// RC servo pulse generator with per-channel angle/width commands and frames.
// ============================================================================
// Usage:
//   Input stream (s_*): one beat per command. s_tuser is the kind: tick of
//   one microsecond, set angle, set width, or force a frame start. Output
//   stream (m_*): exactly one beat per input beat with the pin levels, the
//   frame-start flag and the readback of the addressed channel.
//   APB port: min/max pulse limits, frame period, enable and invert masks.
//   Per-channel state (stored width, angle, latched width) lives in one
//   8-entry RAM; each beat is a read-modify-write sequence over it.
// Sequence:
//   A tick or a force beat sweeps all channels through the RAM, then the
//   addressed entry is read back and m_tvalid rises; the next beat is taken
//   once that result is in the output register. A set beat runs one RAM
//   entry through a 24-step serial divider and writes it back. Writing the
//   min or max limit starts a clamp sweep; s_tready is low until it is done.
// Reset: limits 544/2400 us, period 20000 us, masks clear, all channels
//   unset (width 0, angle 255), no pulse running.
// Stall: a result waits in the output register; the block takes the next
//   beat meanwhile and holds its own result until m_tready frees the slot.
// ============================================================================
module multichannel_servo_pulse_generator (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: channel[2:0], angle_cmd[18:3], width_cmd[34:19], zero pad
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // s_tuser: action[1:0]
  input  logic [1:0]  s_tuser,
  // m_tdata: pin_levels[7:0], frame_start[8], angle_readback[16:9],
  //          width_readback[32:17], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SWR   = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;
  localparam logic [2:0] S_RB    = 3'd5;
  localparam logic [2:0] S_RBW   = 3'd6;

  localparam int CH_IDX_W = msp_pkg::CH_AW + 1;

  // Configuration registers
  logic [15:0] min_pulse;
  logic [15:0] max_pulse;
  logic [15:0] period;
  logic [7:0]  enable_mask;
  logic [7:0]  invert_mask;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic        pend_min;
  logic        pend_max;

  // Control state
  logic [2:0]  state;
  logic [15:0] frame_cnt;
  logic [15:0] cnt_inc;
  logic [7:0]  running;
  logic [CH_IDX_W-1:0] idx;
  logic        rd_go;
  logic [msp_pkg::CH_AW-1:0] rd_ch;
  logic [1:0]  mode;
  logic        sw_min;
  logic        sw_max;
  logic [msp_pkg::DIV_CW-1:0] div_cnt;

  // Current beat
  logic        s_accept;
  logic [1:0]  act;
  logic [msp_pkg::CH_FW-1:0] chan;
  logic        chan_ok;
  logic        in_chan_ok;
  logic signed [15:0] ang_cmd;
  logic [15:0] wid_cmd;
  logic        started;

  // Channel memory
  logic                      ram_we;
  logic [msp_pkg::CH_AW-1:0] ram_waddr;
  logic [msp_pkg::CH_AW-1:0] ram_raddr;
  msp_pkg::ent_t             ram_wdata;
  logic [msp_pkg::ENT_W-1:0] ram_q;
  logic [msp_pkg::CHANNELS-1:0] vld;
  logic                      rd_vld;
  msp_pkg::ent_t             ent_rd;
  msp_pkg::ent_t             ent;
  msp_pkg::ent_t             sweep_ent;
  msp_pkg::ent_t             set_ent;
  logic                      sweep_on;

  // Mapping arithmetic
  logic [7:0]  a_cl;
  logic [7:0]  a_cl_q;
  logic [15:0] w_lo;
  logic [15:0] w_cl;
  logic [15:0] w_cl_q;
  logic [16:0] span;
  logic [15:0] span_mag;
  logic [16:0] dw;
  logic [15:0] dw_mag;
  logic [7:0]  mul_a;
  logic [15:0] mul_b;
  logic [23:0] prod;
  logic [15:0] den;
  logic        neg;
  logic        zero_span;
  logic [msp_pkg::DIV_W-1:0] quo;
  logic [15:0] rem;
  logic [16:0] shifted;
  logic        div_ge;
  logic [15:0] q16;
  logic [7:0]  q8;

  // Output register
  logic [7:0]  out_pins;
  logic        out_start;
  logic [7:0]  out_angle;
  logic [15:0] out_width;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign cfg_idx  = paddr[4:2];
  assign s_tready = (state == S_IDLE) && !pend_min && !pend_max;
  assign s_accept = s_tvalid && s_tready;
  assign m_tdata  = {7'd0, out_width, out_angle, out_start, out_pins};

  assign in_chan_ok = ({1'b0, s_tdata[2:0]} < 4'(msp_pkg::CHANNELS));
  assign chan_ok    = ({1'b0, chan} < 4'(msp_pkg::CHANNELS));
  assign cnt_inc    = (frame_cnt == 16'hffff) ? frame_cnt : frame_cnt + 16'd1;

  // Register readback
  always_comb begin
    case (cfg_idx)
      msp_pkg::REG_MIN:    prdata = {16'd0, min_pulse};
      msp_pkg::REG_MAX:    prdata = {16'd0, max_pulse};
      msp_pkg::REG_PERIOD: prdata = {16'd0, period};
      msp_pkg::REG_ENABLE: prdata = {24'd0, enable_mask};
      msp_pkg::REG_INVERT: prdata = {24'd0, invert_mask};
      default:             prdata = 32'd0;
    endcase
  end

  msp_ram #(
    .WIDTH(msp_pkg::ENT_W),
    .DEPTH(msp_pkg::CHANNELS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  // Entries never written read as their reset value
  assign ent_rd = rd_vld ? msp_pkg::ent_t'(ram_q) : msp_pkg::ENT_RESET;

  // Read address per state
  always_comb begin
    case (state)
      S_IDLE:  ram_raddr = s_tdata[msp_pkg::CH_AW-1:0];
      S_SWEEP: ram_raddr = idx[msp_pkg::CH_AW-1:0];
      S_RB:    ram_raddr = chan[msp_pkg::CH_AW-1:0];
      default: ram_raddr = '0;
    endcase
  end

  // Per-entry update of a sweep
  always_comb begin
    sweep_ent = ent_rd;
    sweep_on  = (ent_rd.width != 16'd0) && enable_mask[rd_ch];
    case (mode)
      msp_pkg::MODE_FRAME: begin
        sweep_ent.latched = sweep_on ? ent_rd.width : 16'd0;
      end
      msp_pkg::MODE_CLAMP: begin
        if (sw_min && (ent_rd.width != 16'd0) && (ent_rd.width < min_pulse)) begin
          sweep_ent.width = min_pulse;
        end
        if (sw_max && (sweep_ent.width != 16'd0) && (sweep_ent.width > max_pulse)) begin
          sweep_ent.width = max_pulse;
        end
      end
      default: sweep_ent = ent_rd;
    endcase
  end

  // Clamp, span and multiplier operands for a set command
  always_comb begin
    if (ang_cmd[15]) begin
      a_cl = 8'd0;
    end else if (ang_cmd[14:0] > 15'(msp_pkg::ANGLE_MAX)) begin
      a_cl = msp_pkg::ANGLE_MAX;
    end else begin
      a_cl = ang_cmd[7:0];
    end
    w_lo     = (wid_cmd < min_pulse) ? min_pulse : wid_cmd;
    w_cl     = (w_lo > max_pulse) ? max_pulse : w_lo;
    span     = {1'b0, max_pulse} - {1'b0, min_pulse};
    span_mag = span[16] ? 16'(-span) : span[15:0];
    dw       = {1'b0, w_cl} - {1'b0, min_pulse};
    dw_mag   = dw[16] ? 16'(-dw) : dw[15:0];
    if (act == msp_pkg::ACT_ANGLE) begin
      mul_a = a_cl;
      mul_b = span_mag;
    end else begin
      mul_a = msp_pkg::ANGLE_MAX;
      mul_b = dw_mag;
    end
    prod = 24'(mul_a) * 24'(mul_b);
  end

  // Divider step and signed quotient
  assign shifted = {rem, quo[msp_pkg::DIV_W-1]};
  assign div_ge  = (shifted >= {1'b0, den});
  assign q16     = neg ? 16'(-quo[15:0]) : quo[15:0];
  assign q8      = neg ? 8'(-quo[7:0]) : quo[7:0];

  // Entry written back by a set command
  always_comb begin
    set_ent = ent;
    if (act == msp_pkg::ACT_ANGLE) begin
      set_ent.width = q16 + min_pulse;
      set_ent.angle = a_cl_q;
    end else begin
      set_ent.width = w_cl_q;
      set_ent.angle = zero_span ? 8'd0 : q8;
    end
  end

  // Write port select
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_ch;
    ram_wdata = sweep_ent;
    if (state == S_SWEEP && rd_go) begin
      ram_we = (mode != msp_pkg::MODE_EXPIRE);
    end else if (state == S_SWR) begin
      ram_we    = 1'b1;
      ram_waddr = chan[msp_pkg::CH_AW-1:0];
      ram_wdata = set_ent;
    end
  end

  // Data path registers
  always_ff @(posedge clk) begin
    rd_vld <= vld[ram_raddr];
    if (s_accept) begin
      act     <= s_tuser;
      chan    <= s_tdata[2:0];
      ang_cmd <= s_tdata[18:3];
      wid_cmd <= s_tdata[34:19];
    end
    if (state == S_MUL) begin
      ent       <= ent_rd;
      a_cl_q    <= a_cl;
      w_cl_q    <= w_cl;
      quo       <= prod;
      rem       <= 16'd0;
      zero_span <= (span == 17'd0);
      if (act == msp_pkg::ACT_ANGLE) begin
        den <= 16'(msp_pkg::ANGLE_MAX);
        neg <= span[16];
      end else begin
        den <= span_mag;
        neg <= dw[16] ^ span[16];
      end
    end else if (state == S_DIV) begin
      rem <= div_ge ? 16'(shifted - {1'b0, den}) : shifted[15:0];
      quo <= {quo[msp_pkg::DIV_W-2:0], div_ge};
    end
    if (state == S_RBW) begin
      out_pins  <= ((running & enable_mask) ^ invert_mask) & msp_pkg::CHAN_BITS;
      out_start <= started;
      out_angle <= chan_ok ? ent_rd.angle : msp_pkg::NO_ANGLE;
      out_width <= chan_ok ? ent_rd.width : 16'd0;
    end
  end

  // Configuration registers and pending limit sweeps
  always_ff @(posedge clk) begin
    if (rst) begin
      min_pulse   <= msp_pkg::MIN_RESET;
      max_pulse   <= msp_pkg::MAX_RESET;
      period      <= msp_pkg::PERIOD_RESET;
      enable_mask <= 8'd0;
      invert_mask <= 8'd0;
      pend_min    <= 1'b0;
      pend_max    <= 1'b0;
    end else begin
      // Flag a limit write; drop the flag once the sequencer takes it
      if (cfg_wr && (cfg_idx == msp_pkg::REG_MIN)) begin
        pend_min <= 1'b1;
      end else if (state == S_IDLE) begin
        pend_min <= 1'b0;
      end
      if (cfg_wr && (cfg_idx == msp_pkg::REG_MAX)) begin
        pend_max <= 1'b1;
      end else if (state == S_IDLE) begin
        pend_max <= 1'b0;
      end
      if (cfg_wr) begin
        case (cfg_idx)
          msp_pkg::REG_MIN:    min_pulse   <= pwdata[15:0];
          msp_pkg::REG_MAX:    max_pulse   <= pwdata[15:0];
          msp_pkg::REG_PERIOD: period      <= pwdata[15:0];
          msp_pkg::REG_ENABLE: enable_mask <= pwdata[7:0];
          msp_pkg::REG_INVERT: invert_mask <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      frame_cnt <= 16'd0;
      running   <= 8'd0;
      vld       <= '0;
      idx       <= '0;
      rd_go     <= 1'b0;
      rd_ch     <= '0;
      mode      <= msp_pkg::MODE_FRAME;
      sw_min    <= 1'b0;
      sw_max    <= 1'b0;
      div_cnt   <= '0;
      started   <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          idx <= '0;
          if (s_accept) begin
            case (s_tuser)
              msp_pkg::ACT_TICK: begin
                state <= S_SWEEP;
                if (cnt_inc >= period) begin
                  frame_cnt <= 16'd0;
                  running   <= 8'd0;
                  started   <= 1'b1;
                  mode      <= msp_pkg::MODE_FRAME;
                end else begin
                  frame_cnt <= cnt_inc;
                  started   <= 1'b0;
                  mode      <= msp_pkg::MODE_EXPIRE;
                end
              end
              msp_pkg::ACT_FORCE: begin
                state     <= S_SWEEP;
                frame_cnt <= 16'd0;
                running   <= 8'd0;
                started   <= 1'b1;
                mode      <= msp_pkg::MODE_FRAME;
              end
              default: begin
                started <= 1'b0;
                state   <= in_chan_ok ? S_MUL : S_RB;
              end
            endcase
          end else if (pend_min || pend_max) begin
            sw_min <= pend_min;
            sw_max <= pend_max;
            mode   <= msp_pkg::MODE_CLAMP;
            state  <= S_SWEEP;
          end
        end
        S_MUL: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt + msp_pkg::DIV_CW'(1);
          if (div_cnt == msp_pkg::DIV_CW'(msp_pkg::DIV_W - 1)) begin
            state <= S_SWR;
          end
        end
        S_SWR: begin
          state <= S_RB;
        end
        S_SWEEP: begin
          // Issue reads in order, update the entry whose data returns
          if (idx < CH_IDX_W'(msp_pkg::CHANNELS)) begin
            rd_go <= 1'b1;
            rd_ch <= idx[msp_pkg::CH_AW-1:0];
            idx   <= idx + CH_IDX_W'(1);
          end else begin
            rd_go <= 1'b0;
            if (!rd_go) begin
              state <= (mode == msp_pkg::MODE_CLAMP) ? S_IDLE : S_RB;
            end
          end
          if (rd_go) begin
            if (mode == msp_pkg::MODE_FRAME) begin
              running[rd_ch] <= sweep_on;
            end else if (mode == msp_pkg::MODE_EXPIRE) begin
              if (running[rd_ch] && (frame_cnt >= ent_rd.latched)) begin
                running[rd_ch] <= 1'b0;
              end
            end
          end
        end
        S_RB: begin
          // Wait for a free output slot, then read the addressed entry
          if (!m_tvalid || m_tready) begin
            state <= S_RBW;
          end
        end
        S_RBW: begin
          m_tvalid <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/msp_ram.sv */
// ============================================================================
// msp_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module msp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* bench/multichannel_servo_pulse_generator_tb.sv */
// ============================================================================
// multichannel_servo_pulse_generator_tb
// Self-checking bench for the servo pulse generator: commands and ticks go in
// on the input stream, every output beat is compared against a behavioral
// model of the channel store, the frame timer and the pin polarity logic.
// ============================================================================
`timescale 1ns / 1ps

module multichannel_servo_pulse_generator_tb;

  typedef struct packed {
    logic [7:0]  pins;
    logic        fs;
    logic [7:0]  angle;
    logic [15:0] width;
  } servo_out_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Model of the channel store, frame timer and registers
  logic [15:0] cmd_width [msp_pkg::CHANNELS];
  logic [7:0]  cmd_angle [msp_pkg::CHANNELS];
  logic [15:0] held_width [msp_pkg::CHANNELS];
  logic [7:0]  active_ch;
  logic [15:0] ticks_since_frame;
  logic [15:0] lim_lo;
  logic [15:0] lim_hi;
  logic [15:0] period_cfg;
  logic [7:0]  en_mask;
  logic [7:0]  inv_mask;

  servo_out_t awaited_outputs[$];
  int         errors = 0;
  bit         stall_free;

  multichannel_servo_pulse_generator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // Latch every enabled channel that holds a width and restart the timer
  function automatic void open_frame();
    ticks_since_frame = '0;
    active_ch = '0;
    for (int i = 0; i < msp_pkg::CHANNELS; i++) begin
      if (en_mask[i] && cmd_width[i] != 16'd0) begin
        held_width[i] = cmd_width[i];
        active_ch[i] = 1'b1;
      end else begin
        held_width[i] = 16'd0;
      end
    end
  endfunction

  // Advance the model by one accepted beat and return the output it implies
  function automatic servo_out_t servo_step(input logic [1:0] act, input logic [2:0] ch,
                                            input logic [15:0] ang, input logic [15:0] wid);
    servo_out_t r;
    int a;
    int w;
    int span;
    r.fs = 1'b0;
    span = int'(lim_hi) - int'(lim_lo);
    case (act)
      msp_pkg::ACT_TICK: begin
        if (ticks_since_frame != 16'hffff) ticks_since_frame++;
        if (ticks_since_frame >= period_cfg) begin
          open_frame();
          r.fs = 1'b1;
        end else begin
          for (int i = 0; i < msp_pkg::CHANNELS; i++)
            if (active_ch[i] && ticks_since_frame >= held_width[i]) active_ch[i] = 1'b0;
        end
      end
      msp_pkg::ACT_FORCE: begin
        open_frame();
        r.fs = 1'b1;
      end
      msp_pkg::ACT_ANGLE: begin
        a = int'($signed(ang));
        if (a < 0) a = 0;
        if (a > int'(msp_pkg::ANGLE_MAX)) a = int'(msp_pkg::ANGLE_MAX);
        w = (a * span) / int'(msp_pkg::ANGLE_MAX) + int'(lim_lo);
        cmd_angle[ch] = a[7:0];
        cmd_width[ch] = w[15:0];
      end
      default: begin
        w = int'(wid);
        if (w < int'(lim_lo)) w = int'(lim_lo);
        if (w > int'(lim_hi)) w = int'(lim_hi);
        if (span == 0) a = 0;
        else a = ((w - int'(lim_lo)) * int'(msp_pkg::ANGLE_MAX)) / span;
        cmd_width[ch] = w[15:0];
        cmd_angle[ch] = a[7:0];
      end
    endcase
    r.pins  = ((active_ch & en_mask) ^ inv_mask) & msp_pkg::CHAN_BITS;
    r.angle = cmd_angle[ch];
    r.width = cmd_width[ch];
    return r;
  endfunction

  // Send one command beat; called and returning at a falling edge
  task automatic send_cmd(input logic [1:0] act, input logic [2:0] ch,
                          input logic [15:0] ang, input logic [15:0] wid);
    if (!stall_free) begin
      while ($urandom_range(99) < 31) begin
        s_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid = 1'b1;
    s_tuser  = act;
    s_tdata  = {5'd0, wid, ang, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    awaited_outputs.push_back(servo_step(act, ch, ang, wid));
    @(negedge clk);
  endtask

  // Write one register once every result is out, then wait out any clamp sweep
  task automatic program_register(input logic [2:0] idx, input logic [15:0] value);
    s_tvalid = 1'b0;
    while (awaited_outputs.size() != 0) @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {16'd0, value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      msp_pkg::REG_MIN: begin
        lim_lo = value;
        for (int i = 0; i < msp_pkg::CHANNELS; i++)
          if (cmd_width[i] != 16'd0 && cmd_width[i] < lim_lo) cmd_width[i] = lim_lo;
      end
      msp_pkg::REG_MAX: begin
        lim_hi = value;
        for (int i = 0; i < msp_pkg::CHANNELS; i++)
          if (cmd_width[i] != 16'd0 && cmd_width[i] > lim_hi) cmd_width[i] = lim_hi;
      end
      msp_pkg::REG_PERIOD: period_cfg = value;
      msp_pkg::REG_ENABLE: en_mask = value[7:0];
      default:             inv_mask = value[7:0];
    endcase
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Angle and width commands at their extremes and in range under the reset limits, then a tick and a force
  task automatic test_set_commands();
    send_cmd(msp_pkg::ACT_ANGLE, 3'd0, 16'h8000, 16'hffff);
    send_cmd(msp_pkg::ACT_ANGLE, 3'd1, 16'h7fff, 16'h0000);
    send_cmd(msp_pkg::ACT_ANGLE, 3'd2, 16'd90, 16'd0);
    send_cmd(msp_pkg::ACT_ANGLE, 3'd7, 16'd181, 16'd0);
    send_cmd(msp_pkg::ACT_ANGLE, 3'd6, 16'hffff, 16'd0);
    send_cmd(msp_pkg::ACT_WIDTH, 3'd3, 16'd0, 16'd0);
    send_cmd(msp_pkg::ACT_WIDTH, 3'd4, 16'd0, 16'hffff);
    send_cmd(msp_pkg::ACT_WIDTH, 3'd5, 16'd0, 16'd1000);
    send_cmd(msp_pkg::ACT_TICK, 3'd7, 16'd0, 16'd0);
    send_cmd(msp_pkg::ACT_FORCE, 3'd2, 16'd0, 16'd0);
  endtask

  // Equal limits, inverted limits, zero mapped width, limit clamps, zero period
  task automatic test_limit_cases();
    program_register(msp_pkg::REG_MIN, 16'd1000);
    program_register(msp_pkg::REG_MAX, 16'd1000);
    send_cmd(msp_pkg::ACT_WIDTH, 3'd3, 16'd0, 16'd5000);
    send_cmd(msp_pkg::ACT_TICK, 3'd1, 16'd0, 16'd0);
    program_register(msp_pkg::REG_MAX, 16'd100);
    send_cmd(msp_pkg::ACT_WIDTH, 3'd4, 16'd0, 16'd7);
    send_cmd(msp_pkg::ACT_ANGLE, 3'd5, 16'd90, 16'd0);
    program_register(msp_pkg::REG_MIN, 16'd0);
    program_register(msp_pkg::REG_MAX, 16'd0);
    send_cmd(msp_pkg::ACT_ANGLE, 3'd2, 16'd45, 16'd0);
    program_register(msp_pkg::REG_ENABLE, 16'h00ff);
    program_register(msp_pkg::REG_INVERT, 16'h000f);
    send_cmd(msp_pkg::ACT_FORCE, 3'd2, 16'd0, 16'd0);
    program_register(msp_pkg::REG_PERIOD, 16'd0);
    send_cmd(msp_pkg::ACT_TICK, 3'd0, 16'd0, 16'd0);
    send_cmd(msp_pkg::ACT_TICK, 3'd4, 16'd0, 16'd0);
  endtask

  // Pulses longer than the frame get relatched by the next frame start
  task automatic test_long_pulse();
    program_register(msp_pkg::REG_MIN, 16'd2);
    program_register(msp_pkg::REG_MAX, 16'hffff);
    program_register(msp_pkg::REG_PERIOD, 16'd5);
    send_cmd(msp_pkg::ACT_WIDTH, 3'd0, 16'd0, 16'd12);
    send_cmd(msp_pkg::ACT_WIDTH, 3'd1, 16'd0, 16'd3);
    send_cmd(msp_pkg::ACT_FORCE, 3'd0, 16'd0, 16'd0);
    repeat (7) send_cmd(msp_pkg::ACT_TICK, 3'd1, 16'd0, 16'd0);
  endtask

  function automatic logic [15:0] pick_setting(input int lo, input int hi);
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'hffff;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  // One phase of random settings followed by a random command mix
  task automatic test_random_frames(input int n_items);
    int          r;
    logic [15:0] ang;
    logic [15:0] wid;
    program_register(msp_pkg::REG_MIN, pick_setting(0, 12));
    program_register(msp_pkg::REG_MAX, pick_setting(4, 40));
    program_register(msp_pkg::REG_PERIOD, pick_setting(1, 50));
    program_register(msp_pkg::REG_ENABLE, 16'(pick_setting(0, 255) & 16'h00ff));
    program_register(msp_pkg::REG_INVERT, 16'(pick_setting(0, 255) & 16'h00ff));
    repeat (n_items) begin
      r   = $urandom_range(99);
      ang = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(200) - 10);
      wid = ($urandom_range(1) == 0) ? 16'($urandom) : 16'(lim_lo + $urandom_range(40));
      if (r < 60)      send_cmd(msp_pkg::ACT_TICK, 3'($urandom), ang, wid);
      else if (r < 75) send_cmd(msp_pkg::ACT_ANGLE, 3'($urandom), ang, wid);
      else if (r < 90) send_cmd(msp_pkg::ACT_WIDTH, 3'($urandom), ang, wid);
      else             send_cmd(msp_pkg::ACT_FORCE, 3'($urandom), ang, wid);
    end
  endtask

  // Output side back-pressure
  always @(negedge clk)
    m_tready <= stall_free ? 1'b1 : ($urandom_range(99) >= 31);

  // Compare each output beat with the oldest prediction
  always @(posedge clk) begin
    servo_out_t want;
    servo_out_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.pins  = m_tdata[7:0];
      got.fs    = m_tdata[8];
      got.angle = m_tdata[16:9];
      got.width = m_tdata[32:17];
      if (awaited_outputs.size() == 0) begin
        $error("output beat with no prediction pending: %h", m_tdata);
        errors++;
      end else begin
        want = awaited_outputs.pop_front();
        if (got.pins !== want.pins) begin
          $error("pin_levels: expected %0h, got %0h", want.pins, got.pins);
          errors++;
        end
        if (got.fs !== want.fs) begin
          $error("frame_start: expected %0d, got %0d", want.fs, got.fs);
          errors++;
        end
        if (got.angle !== want.angle) begin
          $error("angle_readback: expected %0d, got %0d", want.angle, got.angle);
          errors++;
        end
        if (got.width !== want.width) begin
          $error("width_readback: expected %0d, got %0d", want.width, got.width);
          errors++;
        end
      end
    end
  end

  // Hard stop for a hung handshake
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = msp_pkg::ACT_TICK;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    stall_free = 1'b0;
    lim_lo     = msp_pkg::MIN_RESET;
    lim_hi     = msp_pkg::MAX_RESET;
    period_cfg = msp_pkg::PERIOD_RESET;
    en_mask    = '0;
    inv_mask   = '0;
    active_ch  = '0;
    ticks_since_frame = '0;
    for (int i = 0; i < msp_pkg::CHANNELS; i++) begin
      cmd_width[i]  = 16'd0;
      cmd_angle[i]  = msp_pkg::NO_ANGLE;
      held_width[i] = 16'd0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_set_commands();
    test_limit_cases();
    test_long_pulse();
    for (int p = 0; p < 8; p++) begin
      stall_free = (p == 4);
      test_random_frames(65);
    end
    stall_free = 1'b0;

    // Drain, then give the block time to show any stray beat
    s_tvalid = 1'b0;
    while (awaited_outputs.size() != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
src/msp_pkg.sv
src/msp_ram.sv
src/multichannel_servo_pulse_generator.sv
bench/multichannel_servo_pulse_generator_tb.sv
